// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int POS_W       = 10;
    localparam int IN_TDATA_W  = 40;   // op + key, padded to bytes
    localparam int OUT_TDATA_W = 16;   // status + position, padded to bytes

    // command queue depth, power of two
    localparam int QUEUE_DEPTH = 2;

    // operation codes on the input stream
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_HIT  = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS = 2'd3;

    // flipping the sign bit makes an unsigned compare follow signed order
    localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_APPEND,
        K_SEARCH,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] key;   // sign-flipped key
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

endpackage

// ===== rtl/stbs_front.sv =====
// Front end: accepts input transactions and decodes them into queue commands.
module stbs_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [stbs_pkg::OP_W-1:0]   i_op,
    input  logic signed [stbs_pkg::KEY_W-1:0] i_key,
    input  logic                        i_full,
    output logic                        o_push,
    output stbs_pkg::t_cmd              o_cmd
);
    import stbs_pkg::*;

    t_kind kind;

    always_comb begin
        unique case (i_op)
            OP_CLEAR:  kind = K_CLEAR;
            OP_APPEND: kind = K_APPEND;
            OP_SEARCH: kind = K_SEARCH;
            default:   kind = K_NOP;
        endcase
    end

    assign o_ready    = !i_full;
    assign o_push     = i_valid && !i_full;
    assign o_cmd.kind = kind;
    assign o_cmd.key  = unsigned'(i_key) ^ SIGN_FLIP;

endmodule

// ===== rtl/stbs_queue.sv =====
// Small command FIFO between the front end and the search engine.
module stbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stbs_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output stbs_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import stbs_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

endmodule

// ===== rtl/stbs_back.sv =====
// Back end: key table memory, count, binary search engine and result register.
module stbs_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  stbs_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [stbs_pkg::ST_W-1:0]   o_out_status,
    output logic [stbs_pkg::POS_W-1:0]  o_out_position
);
    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (AW > POS_W) ? AW : POS_W;

    // table memory, sync read
    logic [KEY_W-1:0] r_table [TABLE_DEPTH];
    logic [KEY_W-1:0] r_rdata;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [AW-1:0]    r_mid, n_mid;
    logic [KEY_W-1:0] r_key, n_key;
    logic [ST_W-1:0]  r_status, n_status;
    logic [AW-1:0]    r_pos, n_pos;

    logic             r_out_valid;
    logic [ST_W-1:0]  r_out_status;
    logic [POS_W-1:0] r_out_pos;

    logic             out_free;
    logic             wr_en;
    logic             rd_en;
    logic [CW-1:0]    probe_lo;
    logic [CW-1:0]    probe_hi;
    logic [CW:0]      probe_sum;
    logic [AW-1:0]    probe_mid;
    logic             probe_go;
    logic [IW-1:0]    pos_ext;

    assign out_free  = !r_out_valid || i_out_ready;
    // mid = lo + ((hi - 1 - lo) >> 1) == (lo + hi - 1) >> 1 when lo < hi
    assign probe_sum = {1'b0, probe_lo} + {1'b0, probe_hi} - (CW + 1)'(1);
    assign probe_mid = probe_sum[AW:1];
    assign probe_go  = probe_lo < probe_hi;
    assign pos_ext   = IW'(r_pos);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_key    = r_key;
        n_status = r_status;
        n_pos    = r_pos;
        o_q_pop  = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        probe_lo = '0;
        probe_hi = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_key    = i_q_cmd.key;
                    n_pos    = '0;
                    n_status = ST_DONE;
                    n_state  = S_RESULT;
                    unique case (i_q_cmd.kind)
                        K_CLEAR: begin
                            n_count = '0;
                        end
                        K_APPEND: begin
                            if (r_count < CW'(TABLE_DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                n_pos   = r_count[AW-1:0];
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        K_SEARCH: begin
                            if (probe_go) begin
                                rd_en   = 1'b1;
                                n_lo    = probe_lo;
                                n_hi    = probe_hi;
                                n_mid   = probe_mid;
                                n_state = S_SEARCH;
                            end else begin
                                n_status = ST_MISS;
                            end
                        end
                        K_NOP: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                probe_lo = (r_rdata < r_key) ? CW'(r_mid) + CW'(1) : r_lo;
                probe_hi = (r_rdata > r_key) ? CW'(r_mid) : r_hi;
                if (r_rdata == r_key) begin
                    n_status = ST_HIT;
                    n_pos    = r_mid;
                    n_state  = S_RESULT;
                end else if (probe_go) begin
                    rd_en = 1'b1;
                    n_lo  = probe_lo;
                    n_hi  = probe_hi;
                    n_mid = probe_mid;
                end else begin
                    n_status = ST_MISS;
                    n_pos    = '0;
                    n_state  = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_status <= n_status;
        r_pos    <= n_pos;
        if (r_state == S_RESULT && out_free) begin
            r_out_status <= r_status;
            r_out_pos    <= pos_ext[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[r_count[AW-1:0]] <= i_q_cmd.key;
        end
        if (rd_en) begin
            r_rdata <= r_table[probe_mid];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_out_position = r_out_pos;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("key count above table depth");

    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo < r_hi) && (r_hi <= r_count))
        else $error("search window empty or beyond count");

    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (CW'(r_mid) >= r_lo) && (CW'(r_mid) < r_hi))
        else $error("probe outside search window");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) && i_q_valid)
        else $error("command taken while engine busy");

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Top level of the sorted key table with binary search.
// Holds up to TABLE_DEPTH signed 32-bit keys, appended in ascending order
// (the order is not checked), and answers clear, append and search
// transactions with exactly one result each. The front end decodes each
// input transaction into a two-entry command queue; the back end takes one
// command at a time from the queue, so input and output stall independently.
// Clear, append and the unused operation code go from idle to result state.
// A search probes in the search state: the table is a single-port
// memory with registered read data, and one probe (read, compare, narrow the
// window, issue the next address) completes per cycle, so a table holding n
// keys needs at most floor(log2(n)) + 1 probes, 11 for 1024 keys. An empty
// table misses with no read. The result sits in an output register while the
// next command is being worked on. A full-table append returns status full.
// The table is not cleared at reset; entries above the count are never read.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] operation, [33:2] key, [39:34] zero
    input  logic [stbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [11:2] position, [15:12] zero
    output logic [stbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import stbs_pkg::*;

    logic [OP_W-1:0]         in_op;
    logic signed [KEY_W-1:0] in_key;
    logic                    q_full;
    logic                    q_push;
    t_cmd                    q_in_cmd;
    logic                    q_valid;
    t_cmd                    q_out_cmd;
    logic                    q_pop;
    logic [ST_W-1:0]         out_status;
    logic [POS_W-1:0]        out_position;

    // unpack the input transaction
    assign in_op  = s_axis_tdata[OP_W-1:0];
    assign in_key = signed'(s_axis_tdata[OP_W +: KEY_W]);

    stbs_front u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (in_op),
        .i_key   (in_key),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in_cmd)
    );

    stbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    // search engine and table
    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_out_cmd),
        .o_q_pop        (q_pop),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_status   (out_status),
        .o_out_position (out_position)
    );

    // pack the result transaction
    assign m_axis_tdata = {(OUT_TDATA_W - POS_W - ST_W)'(0), out_position, out_status};

endmodule
